### rtl/mi3_pkg.sv
package mi3_pkg;

	// element format
	localparam int ELEM_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int N_ELEM = 9;

	// exact intermediate widths
	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int COF_W = 2 * ELEM_WIDTH + 1;
	localparam int DPROD_W = 3 * ELEM_WIDTH + 1;
	localparam int DET_W = 3 * ELEM_WIDTH + 3;
	localparam int NUM_W = COF_W + 2 * FRAC_BITS;
	localparam int REM_W = ((NUM_W > DET_W + ELEM_WIDTH) ? NUM_W : DET_W + ELEM_WIDTH) + 1;

	// stream widths
	localparam int DATA_W = ((N_ELEM * ELEM_WIDTH + 7) / 8) * 8;
	localparam int USER_W = 2;
	localparam int USER_SINGULAR = 0;
	localparam int USER_SATURATED = 1;

	// latency
	localparam int FRONT_LAT = 5;
	localparam int LANE_LAT = ELEM_WIDTH + 3;
	localparam int PIPE_LAT = FRONT_LAT + LANE_LAT;

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;
	typedef logic [COF_W-1:0] cof_t;
	typedef logic [DET_W-1:0] det_t;

endpackage

### rtl/mi3_front.sv
module mi3_front
	import mi3_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  elem_t m [N_ELEM],
	output cof_t  cof [N_ELEM],
	output det_t  det
);

	logic signed [PROD_W-1:0] prod_s1 [2*N_ELEM];
	elem_t mcol_s1 [3];
	elem_t mcol_s2 [3];
	cof_t cof_s2 [N_ELEM];
	cof_t cof_s3 [N_ELEM];
	cof_t cof_s4 [N_ELEM];
	cof_t cof_s5 [N_ELEM];
	logic signed [PROD_W:0] plo_s3 [3];
	logic signed [PROD_W:0] phi_s3 [3];
	logic [DPROD_W-1:0] dp_s4 [3];
	det_t det_s5;

	// operand pairs of each 2x2 minor, entry index r*3+c
	localparam int OPA [2*N_ELEM] = '{4, 8, 2, 7, 1, 5, 5, 6, 0, 8, 2, 3, 3, 7, 1, 6, 0, 4};
	localparam int OPB [2*N_ELEM] = '{5, 7, 1, 8, 2, 4, 3, 8, 2, 6, 0, 5, 4, 6, 0, 7, 1, 3};

	// minor products, two per cofactor
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ELEM; i++) begin
				prod_s1[2*i] <= m[OPA[2*i]] * m[OPA[2*i+1]];
				prod_s1[2*i+1] <= m[OPB[2*i]] * m[OPB[2*i+1]];
			end
			mcol_s1[0] <= m[0];
			mcol_s1[1] <= m[3];
			mcol_s1[2] <= m[6];
		end
	end

	// cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ELEM; i++) begin
				cof_s2[i] <= {prod_s1[2*i][PROD_W-1], prod_s1[2*i]}
					- {prod_s1[2*i+1][PROD_W-1], prod_s1[2*i+1]};
			end
			mcol_s2 <= mcol_s1;
		end
	end

	// determinant partial products, cofactor split into low and high halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= mcol_s2[j] * $signed({1'b0, cof_s2[j][ELEM_WIDTH-1:0]});
				phi_s3[j] <= mcol_s2[j] * $signed(cof_s2[j][COF_W-1:ELEM_WIDTH]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// recombine partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dp_s4[j] <= {phi_s3[j], {ELEM_WIDTH{1'b0}}}
					+ {{ELEM_WIDTH{plo_s3[j][PROD_W]}}, plo_s3[j]};
			end
			cof_s4 <= cof_s3;
		end
	end

	// expansion along the first column
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= {{2{dp_s4[0][DPROD_W-1]}}, dp_s4[0]}
				+ {{2{dp_s4[1][DPROD_W-1]}}, dp_s4[1]}
				+ {{2{dp_s4[2][DPROD_W-1]}}, dp_s4[2]};
			cof_s5 <= cof_s4;
		end
	end

	assign cof = cof_s5;
	assign det = det_s5;

endmodule

### rtl/mi3_div_lane.sv
module mi3_div_lane
	import mi3_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  cof_t                  cof,
	input  det_t                  det,
	output logic [ELEM_WIDTH-1:0] inv,
	output logic                  sat
);

	localparam int STEPS = ELEM_WIDTH + 1;

	logic [REM_W-1:0] rem_s [STEPS+1];
	det_t den_s [STEPS+1];
	logic neg_s [STEPS+1];
	logic ovf_s [STEPS+1];
	logic [ELEM_WIDTH-1:0] quo_s [STEPS+1];
	logic [COF_W-1:0] cof_mag;
	det_t det_mag;
	logic [ELEM_WIDTH-1:0] limit;
	logic [ELEM_WIDTH-1:0] mag_sat;
	logic sat_d;
	logic [ELEM_WIDTH-1:0] inv_q;
	logic sat_q;

	// magnitudes and sign of the quotient
	assign cof_mag = cof[COF_W-1] ? (~cof + 1'b1) : cof;
	assign det_mag = det[DET_W-1] ? (~det + 1'b1) : det;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= REM_W'({cof_mag, {(2*FRAC_BITS){1'b0}}});
			den_s[0] <= det_mag;
			neg_s[0] <= cof[COF_W-1] ^ det[DET_W-1];
			ovf_s[0] <= 1'b0;
			quo_s[0] <= '0;
		end
	end

	// one quotient bit per stage; first stage only checks for overflow
	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		localparam int K = STEPS - j;
		logic [REM_W-1:0] dsh;
		logic ge;

		assign dsh = REM_W'(den_s[j-1]) << K;
		assign ge = rem_s[j-1] >= dsh;

		if (j == 1) begin : g_ovf
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= rem_s[j-1];
					ovf_s[j] <= ovf_s[j-1] | ge;
					quo_s[j] <= quo_s[j-1];
				end
			end
		end else begin : g_bit
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? rem_s[j-1] - dsh : rem_s[j-1];
					ovf_s[j] <= ovf_s[j-1];
					quo_s[j] <= quo_s[j-1] | (ELEM_WIDTH'(ge) << K);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	// saturation and sign
	assign limit = neg_s[STEPS] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
		: {1'b0, {(ELEM_WIDTH-1){1'b1}}};
	assign sat_d = ovf_s[STEPS] || (quo_s[STEPS] > limit);
	assign mag_sat = sat_d ? limit : quo_s[STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q <= neg_s[STEPS] ? (~mag_sat + 1'b1) : mag_sat;
			sat_q <= sat_d;
		end
	end

	assign inv = inv_q;
	assign sat = sat_q;

endmodule

### rtl/mat3_inverse.sv
// channel   dir  tdata                          tuser
// s_axis    in   m00..m22, 32 bits each         -
// m_axis    out  inv00..inv22, 32 bits each     singular, saturated
//
// one matrix per cycle while the skid is empty; the divider in each lane
// resolves one quotient bit per stage
// reset clears only the valid bits of the pipeline, output register and skid
// a stall at m_tready fills a one-item skid, then freezes the whole pipeline
module mat3_inverse
	import mi3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // inv00, inv01, ..., inv22
	output logic [USER_W-1:0] m_tuser   // singular, saturated
);

	logic en;
	elem_t m [N_ELEM];
	cof_t cof [N_ELEM];
	det_t det;
	logic [ELEM_WIDTH-1:0] inv [N_ELEM];
	logic lane_sat [N_ELEM];
	logic vld_q [PIPE_LAT];
	logic sing_q [LANE_LAT];
	logic pipe_vld;
	logic any_sat;
	logic [DATA_W-1:0] new_data;
	logic [USER_W-1:0] new_user;
	logic out_vld_q;
	logic skid_vld_q;
	logic [DATA_W-1:0] out_data_q;
	logic [USER_W-1:0] out_user_q;
	logic [DATA_W-1:0] skid_data_q;
	logic [USER_W-1:0] skid_user_q;

	assign en = !skid_vld_q;
	assign s_tready = en;

	// unpack input item
	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			m[i] = s_tdata[i*ELEM_WIDTH +: ELEM_WIDTH];
		end
	end

	mi3_front u_front (
		.clk (clk),
		.en  (en),
		.m   (m),
		.cof (cof),
		.det (det)
	);

	for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
		mi3_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.cof (cof[i]),
			.det (det),
			.inv (inv[i]),
			.sat (lane_sat[i])
		);
	end

	// valid and singular tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < PIPE_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_q[0] <= (det == '0);
			for (int i = 1; i < LANE_LAT; i++) sing_q[i] <= sing_q[i-1];
		end
	end

	assign pipe_vld = vld_q[PIPE_LAT-1];

	// merge lanes
	always_comb begin
		any_sat = 1'b0;
		new_data = '0;
		for (int i = 0; i < N_ELEM; i++) begin
			any_sat = any_sat | lane_sat[i];
			if (!sing_q[LANE_LAT-1]) new_data[i*ELEM_WIDTH +: ELEM_WIDTH] = inv[i];
		end
		new_user = '0;
		new_user[USER_SINGULAR] = sing_q[LANE_LAT-1];
		new_user[USER_SATURATED] = any_sat & !sing_q[LANE_LAT-1];
	end

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (pipe_vld) begin
				if (!out_vld_q || m_tready) out_vld_q <= 1'b1;
				else skid_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_vld_q <= 1'b0;
		end
	end

	// output register and skid data
	always_ff @(posedge clk) begin
		if (en) begin
			if (pipe_vld) begin
				if (!out_vld_q || m_tready) begin
					out_data_q <= new_data;
					out_user_q <= new_user;
				end else begin
					skid_data_q <= new_data;
					skid_user_q <= new_user;
				end
			end
		end else if (m_tready) begin
			out_data_q <= skid_data_q;
			out_user_q <= skid_user_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	// skid holds an item only behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid full with empty output register");

	// singular result carries zero entries and no saturation
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[USER_SINGULAR]) |-> (m_tdata == '0 && !m_tuser[USER_SATURATED]))
		else $error("singular item with nonzero payload");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid filled without output stall");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench
	import mi3_pkg::*;
;

	typedef logic signed [127:0] exact_t;

	typedef struct {
		logic [DATA_W-1:0] mat;
		logic              known;
		logic [DATA_W-1:0] inv;
		logic [USER_W-1:0] flags;
	} stim_row_t;

	localparam int ONE_Q = 1 << FRAC_BITS;
	localparam int TIMEOUT_CYCLES = 2000000;
	localparam int RANDOM_ITEMS = 1400;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;  // m00, m01, ..., m22
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;  // inv00, inv01, ..., inv22
	logic [USER_W-1:0] m_tuser;  // singular, saturated

	logic [DATA_W-1:0] inv_expected[$];
	logic [USER_W-1:0] flags_expected[$];
	int mismatches;
	int sent_items;
	int src_idle_pct;
	int dst_idle_pct;
	int cycle_count;
	bit hold_done;
	int hold_left;
	stim_row_t directed[$];

	mat3_inverse uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// exact adjugate over determinant, truncated and saturated per entry
	function automatic void invert_matrix(input logic [DATA_W-1:0] mat,
			output logic [DATA_W-1:0] inv, output logic [USER_W-1:0] flags);
		exact_t m[9];
		exact_t cof[9];
		exact_t det;
		elem_t e;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quot;
		logic [127:0] limit;
		logic neg;
		inv = '0;
		flags = '0;
		for (int i = 0; i < 9; i++) begin
			e = mat[i*ELEM_WIDTH +: ELEM_WIDTH];
			m[i] = e;
		end
		cof[0] = m[4] * m[8] - m[5] * m[7];
		cof[1] = m[2] * m[7] - m[1] * m[8];
		cof[2] = m[1] * m[5] - m[2] * m[4];
		cof[3] = m[5] * m[6] - m[3] * m[8];
		cof[4] = m[0] * m[8] - m[2] * m[6];
		cof[5] = m[2] * m[3] - m[0] * m[5];
		cof[6] = m[3] * m[7] - m[4] * m[6];
		cof[7] = m[1] * m[6] - m[0] * m[7];
		cof[8] = m[0] * m[4] - m[1] * m[3];
		det = m[0] * cof[0] + m[3] * cof[1] + m[6] * cof[2];
		if (det == 0) begin
			flags[USER_SINGULAR] = 1'b1;
			return;
		end
		den = (det < 0) ? -det : det;
		for (int i = 0; i < 9; i++) begin
			neg = (cof[i] < 0) != (det < 0);
			num = ((cof[i] < 0) ? -cof[i] : cof[i]) << (2 * FRAC_BITS);
			quot = num / den;
			limit = neg ? (128'd1 << (ELEM_WIDTH - 1)) : (128'd1 << (ELEM_WIDTH - 1)) - 1;
			if (quot > limit) begin
				quot = limit;
				flags[USER_SATURATED] = 1'b1;
			end
			if (neg)
				quot = -quot;
			inv[i*ELEM_WIDTH +: ELEM_WIDTH] = quot[ELEM_WIDTH-1:0];
		end
	endfunction

	function automatic logic [DATA_W-1:0] pack_matrix(input elem_t e[9]);
		logic [DATA_W-1:0] d;
		d = '0;
		for (int i = 0; i < 9; i++)
			d[i*ELEM_WIDTH +: ELEM_WIDTH] = e[i];
		return d;
	endfunction

	function automatic logic [DATA_W-1:0] diag_matrix(input elem_t a, input elem_t b,
			input elem_t c);
		elem_t e[9];
		foreach (e[i]) e[i] = '0;
		e[0] = a;
		e[4] = b;
		e[8] = c;
		return pack_matrix(e);
	endfunction

	// random matrix, mostly well-conditioned with some singular and extreme cases
	function automatic logic [DATA_W-1:0] random_matrix();
		elem_t e[9];
		int kind;
		kind = $urandom_range(9);
		foreach (e[i]) begin
			case (kind)
				0, 1: begin
					e[i] = $urandom;
				end
				9: begin
					e[i] = $urandom_range(0, 16) - 8;
				end
				default: begin
					e[i] = $urandom_range(0, 1 << 19) - (1 << 18);
				end
			endcase
		end
		if (kind == 7) begin
			// repeated row, determinant exactly zero
			e[6] = e[0];
			e[7] = e[1];
			e[8] = e[2];
		end else if (kind == 8) begin
			e[0] = e[0] + 4 * ONE_Q;
			e[4] = e[4] + 4 * ONE_Q;
			e[8] = e[8] + 4 * ONE_Q;
		end
		return pack_matrix(e);
	endfunction

	// offer one item, wait for acceptance, record its expected result
	task automatic send_matrix(input logic [DATA_W-1:0] mat, input logic known,
			input logic [DATA_W-1:0] inv, input logic [USER_W-1:0] flags);
		logic [DATA_W-1:0] p_inv;
		logic [USER_W-1:0] p_flags;
		if (known) begin
			p_inv = inv;
			p_flags = flags;
		end else begin
			invert_matrix(mat, p_inv, p_flags);
		end
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= mat;
		s_tvalid <= 1'b1;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		inv_expected.push_back(p_inv);
		flags_expected.push_back(p_flags);
		sent_items++;
		@(negedge clk);
	endtask

	// receiver ready, with one long hold-off early in the run
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_items >= 60) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (inv_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: tdata=%h tuser=%b", m_tdata, m_tuser);
			end else begin
				logic [DATA_W-1:0] x_inv;
				logic [USER_W-1:0] x_flags;
				x_inv = inv_expected.pop_front();
				x_flags = flags_expected.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (m_tdata[i*ELEM_WIDTH +: ELEM_WIDTH] !== x_inv[i*ELEM_WIDTH +: ELEM_WIDTH]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("inv entry %0d: expected %h got %h", i,
								x_inv[i*ELEM_WIDTH +: ELEM_WIDTH],
								m_tdata[i*ELEM_WIDTH +: ELEM_WIDTH]);
					end
				end
				if (m_tuser[USER_SINGULAR] !== x_flags[USER_SINGULAR]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("singular: expected %b got %b", x_flags[USER_SINGULAR],
							m_tuser[USER_SINGULAR]);
				end
				if (m_tuser[USER_SATURATED] !== x_flags[USER_SATURATED]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("saturated: expected %b got %b", x_flags[USER_SATURATED],
							m_tuser[USER_SATURATED]);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// main sequence
	initial begin
		stim_row_t row;
		elem_t e[9];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		sent_items = 0;
		cycle_count = 0;
		src_idle_pct = 9;
		dst_idle_pct = 58;

		// directed rows: identity, zero and constant (singular) matrices have results known by inspection
		row.known = 1'b1;
		row.mat = diag_matrix(ONE_Q, ONE_Q, ONE_Q);
		row.inv = row.mat;
		row.flags = '0;
		directed.push_back(row);
		row.mat = '0;
		row.inv = '0;
		row.flags = '0;
		row.flags[USER_SINGULAR] = 1'b1;
		directed.push_back(row);
		row.mat = '1;
		directed.push_back(row);
		foreach (e[i]) e[i] = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
		row.mat = pack_matrix(e);
		directed.push_back(row);
		foreach (e[i]) e[i] = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
		row.mat = pack_matrix(e);
		directed.push_back(row);
		row.inv = '0;
		row.flags = '0;
		row.known = 1'b0;
		// scaled diagonals: exact, tiny (saturating), extreme magnitudes and signs
		row.mat = diag_matrix(2 * ONE_Q, -4 * ONE_Q, ONE_Q / 2);
		directed.push_back(row);
		row.mat = diag_matrix(1, 1, 1);
		directed.push_back(row);
		row.mat = diag_matrix(-1, 1, -1);
		directed.push_back(row);
		row.mat = diag_matrix(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		directed.push_back(row);
		row.mat = diag_matrix(32'sh80000000, 32'sh80000000, 32'sh80000000);
		directed.push_back(row);
		row.mat = diag_matrix(32'sh80000000, 32'sh7fffffff, -1);
		directed.push_back(row);
		row.mat = diag_matrix(3 * ONE_Q, 3 * ONE_Q, 3 * ONE_Q);
		directed.push_back(row);
		// permutation and full matrices
		foreach (e[i]) e[i] = '0;
		e[1] = ONE_Q;
		e[5] = -ONE_Q;
		e[6] = ONE_Q;
		row.mat = pack_matrix(e);
		directed.push_back(row);
		foreach (e[i]) e[i] = (i + 1) * ONE_Q + (i * 4099);
		row.mat = pack_matrix(e);
		directed.push_back(row);
		foreach (e[i]) e[i] = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
		row.mat = pack_matrix(e);
		directed.push_back(row);
		for (int i = 0; i < 6; i++) begin
			row.mat = random_matrix();
			directed.push_back(row);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_matrix(directed[i].mat, directed[i].known, directed[i].inv,
				directed[i].flags);

		// three idling phases for the random part
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				src_idle_pct = 58;
				dst_idle_pct = 9;
			end else if (ph == 2) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			for (int n = 0; n < RANDOM_ITEMS / 3; n++)
				send_matrix(random_matrix(), 1'b0, '0, '0);
		end
		s_tvalid <= 1'b0;

		// drain
		while (inv_expected.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### mat3_inverse.f
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_div_lane.sv
rtl/mat3_inverse.sv
verif/testbench.sv
